FILE: hw/rtl/fvg_pkg.sv
// ============================================================================
// fvg_pkg - FAT volume geometry shared definitions
// Types and constants for the boot block geometry pipeline.
// ============================================================================
`default_nettype none

package fvg_pkg;

    localparam int unsigned IN_W  = 192;
    localparam int unsigned OUT_W = 232;

    localparam int unsigned RDS_BITS  = 13;
    localparam int unsigned CLUS_BITS = 32;

    // Stage map: capture, root-dir divide, metadata sum, subtract, cluster divide
    localparam int unsigned S_MUL  = 1 + RDS_BITS;
    localparam int unsigned S_SUB  = S_MUL + 1;
    localparam int unsigned S_CLUS = S_SUB + 1;
    localparam int unsigned NSTG   = S_CLUS + CLUS_BITS;

    localparam logic [15:0] MIN_SECTOR_BYTES = 16'd512;
    localparam logic [31:0] LIMIT_FAT12      = 32'd4085;
    localparam logic [31:0] LIMIT_FAT16      = 32'd65525;
    localparam logic [31:0] LIMIT_FAT32      = 32'd268435445;

    localparam logic [1:0] TYPE_FAT12 = 2'd0;
    localparam logic [1:0] TYPE_FAT16 = 2'd1;
    localparam logic [1:0] TYPE_FAT32 = 2'd2;
    localparam logic [1:0] TYPE_ERROR = 2'd3;

    typedef struct packed {
        logic        bad;
        logic [31:0] total;
        logic [31:0] fat;
        logic [15:0] rsv;
        logic [7:0]  nfat;
        logic [31:0] rclus;
        logic [7:0]  spc;
        logic [15:0] bps;
        logic [21:0] rrem;
        logic [12:0] rq;
        logic [39:0] meta;
        logic        ovf;
        logic [31:0] data;
        logic [31:0] crem;
        logic [31:0] cq;
    } t_item;

    typedef struct packed {
        logic        ovf;
        logic        bad;
        logic [31:0] root_start;
        logic [1:0]  volume_type;
        logic [31:0] cluster_count;
        logic [31:0] data_sectors;
        logic [15:0] fat_start;
        logic [31:0] data_start;
        logic [12:0] root_dir_sectors;
        logic [31:0] fat_sectors;
        logic [31:0] total_sectors;
    } t_res;

endpackage

`default_nettype wire

FILE: hw/rtl/fat_volume_geometry.sv
// ============================================================================
// fat_volume_geometry - FAT boot block geometry and type detection
// Derives layout, cluster count and FAT type from boot block fields.
// ============================================================================
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  boot block fields, 192 bits
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  geometry result, 232 bits
//
// One transfer per cycle sustained while the output is taken. The depth is mostly set by the
// two restoring dividers: 13 stages for root directory sectors and 32 stages
// for the cluster count, one quotient bit per stage.
// Synchronous active-low reset clears the valid bits only.
// The whole pipeline holds while the output register is full and not taken.
`default_nettype none

module fat_volume_geometry (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // bytes_per_sector[15:0], sectors_per_cluster[23:16], reserved_sectors[39:24],
    // fat_count[47:40], root_entries[63:48], total_sectors_small[79:64],
    // total_sectors_large[111:80], fat_size_small[127:112],
    // fat_size_large[159:128], root_cluster[191:160]
    input  wire logic [191:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // total_sectors[31:0], fat_sectors[63:32], root_dir_sectors[76:64],
    // data_start[108:77], fat_start[124:109], data_sectors[156:125],
    // cluster_count[188:157], volume_type[190:189], root_start[222:191],
    // bad_parameters[223], metadata_overflow[224], zero pad[231:225]
    output logic [231:0]      o_m_axis_tdata
);

    localparam int unsigned NSTG = fvg_pkg::NSTG;

    fvg_pkg::t_item r_st [NSTG];
    logic [NSTG:0]  r_v;
    fvg_pkg::t_res  r_res;
    logic           en;

    // Capture: select counts, build the rounded-up root directory numerator.
    function automatic fvg_pkg::t_item f_capture(input logic [191:0] d);
        fvg_pkg::t_item s;
        logic [15:0] tss;
        logic [15:0] fss;
        s      = '0;
        s.bps  = d[15:0];
        s.spc  = d[23:16];
        s.rsv  = d[39:24];
        s.nfat = d[47:40];
        tss    = d[79:64];
        fss    = d[127:112];
        s.total = (tss != 16'd0) ? {16'd0, tss} : d[111:80];
        s.fat   = (fss != 16'd0) ? {16'd0, fss} : d[159:128];
        s.rclus = d[191:160];
        s.bad   = (s.bps < fvg_pkg::MIN_SECTOR_BYTES) || (s.spc == 8'd0);
        s.rrem  = {1'b0, d[63:48], 5'd0} + {6'd0, s.bps} - 22'd1;
        return s;
    endfunction

    function automatic fvg_pkg::t_item f_rds_step(input fvg_pkg::t_item si,
                                                  input logic [3:0] b);
        fvg_pkg::t_item s;
        logic [28:0] dsh;
        s   = si;
        dsh = {13'd0, s.bps} << b;
        if ({7'd0, s.rrem} >= dsh) begin
            s.rrem  = s.rrem - dsh[21:0];
            s.rq[b] = 1'b1;
        end
        return s;
    endfunction

    function automatic fvg_pkg::t_item f_meta(input fvg_pkg::t_item si);
        fvg_pkg::t_item s;
        logic [39:0] p;
        s      = si;
        p      = {32'd0, s.nfat} * {8'd0, s.fat};
        s.meta = {24'd0, s.rsv} + p + {27'd0, s.rq};
        return s;
    endfunction

    function automatic fvg_pkg::t_item f_sub(input fvg_pkg::t_item si);
        fvg_pkg::t_item s;
        s      = si;
        s.ovf  = (s.meta[39:32] != 8'd0) || (s.meta[31:0] > s.total);
        s.data = s.ovf ? 32'd0 : s.total - s.meta[31:0];
        s.crem = s.data;
        s.cq   = '0;
        return s;
    endfunction

    function automatic fvg_pkg::t_item f_clus_step(input fvg_pkg::t_item si,
                                                   input logic [4:0] b);
        fvg_pkg::t_item s;
        logic [39:0] dsh;
        s   = si;
        dsh = {32'd0, s.spc} << b;
        if ({8'd0, s.crem} >= dsh) begin
            s.crem  = s.crem - dsh[31:0];
            s.cq[b] = 1'b1;
        end
        return s;
    endfunction

    // Classify and format; bad parameters force zeros and the error type.
    function automatic fvg_pkg::t_res f_result(input fvg_pkg::t_item s);
        fvg_pkg::t_res r;
        logic [1:0] ty;
        r = '0;
        if (s.cq < fvg_pkg::LIMIT_FAT12) begin
            ty = fvg_pkg::TYPE_FAT12;
        end else if (s.cq < fvg_pkg::LIMIT_FAT16) begin
            ty = fvg_pkg::TYPE_FAT16;
        end else if (s.cq < fvg_pkg::LIMIT_FAT32) begin
            ty = fvg_pkg::TYPE_FAT32;
        end else begin
            ty = fvg_pkg::TYPE_ERROR;
        end
        if (s.bad) begin
            r.bad         = 1'b1;
            r.volume_type = fvg_pkg::TYPE_ERROR;
        end else begin
            r.total_sectors    = s.total;
            r.fat_sectors      = s.fat;
            r.root_dir_sectors = s.rq;
            r.data_start       = s.meta[31:0];
            r.fat_start        = s.rsv;
            r.data_sectors     = s.data;
            r.cluster_count    = s.cq;
            r.volume_type      = ty;
            r.root_start       = (ty == fvg_pkg::TYPE_FAT12 || ty == fvg_pkg::TYPE_FAT16)
                               ? s.meta[31:0] - {19'd0, s.rq} : s.rclus;
            r.ovf              = s.ovf;
        end
        return r;
    endfunction

    // Advance everything whenever the output register is free or being taken.
    assign en              = !r_v[NSTG] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_v[NSTG];
    assign o_m_axis_tdata  = {7'd0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-1:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= f_capture(i_s_axis_tdata);
            for (int k = 1; k < NSTG; k++) begin
                if (k < fvg_pkg::S_MUL) begin
                    r_st[k] <= f_rds_step(r_st[k-1], 4'(fvg_pkg::S_MUL - 1 - k));
                end else if (k == fvg_pkg::S_MUL) begin
                    r_st[k] <= f_meta(r_st[k-1]);
                end else if (k == fvg_pkg::S_SUB) begin
                    r_st[k] <= f_sub(r_st[k-1]);
                end else begin
                    r_st[k] <= f_clus_step(r_st[k-1], 5'(NSTG - 1 - k));
                end
            end
            r_res <= f_result(r_st[NSTG-1]);
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_fat_volume_geometry.sv
// ============================================================================
// tb_fat_volume_geometry - regression bench for the FAT geometry pipeline
// Drives boot block fields into the stream input, predicts the layout, cluster
// count and volume type of each block, and checks every output transfer in
// order, with random gaps on both sides and one long output hold-off.
// ============================================================================
`default_nettype none

class geometry_scoreboard;
    fvg_pkg::t_res pending_layouts[$];
    int            errors;

    // Compute the expected geometry of one boot block and queue it.
    function void note_block(logic [191:0] blk);
        logic [15:0] bps, rsv, nroot, tss, fss;
        logic [7:0]  spc, nfat;
        logic [31:0] tsl, fsl, rclus, total, fat, data, clus;
        logic [63:0] rds, meta;
        logic        ovf;
        fvg_pkg::t_res r;
        bps   = blk[15:0];    spc = blk[23:16];  rsv = blk[39:24];
        nfat  = blk[47:40];   nroot = blk[63:48]; tss = blk[79:64];
        tsl   = blk[111:80];  fss = blk[127:112]; fsl = blk[159:128];
        rclus = blk[191:160];
        r = '0;
        if (bps < fvg_pkg::MIN_SECTOR_BYTES || spc == 0) begin
            r.volume_type = fvg_pkg::TYPE_ERROR;
            r.bad = 1'b1;
        end else begin
            total = (tss != 0) ? {16'd0, tss} : tsl;
            fat   = (fss != 0) ? {16'd0, fss} : fsl;
            rds   = (64'(nroot) * 64'd32 + 64'(bps) - 64'd1) / 64'(bps);
            meta  = 64'(rsv) + 64'(nfat) * 64'(fat) + rds;
            ovf   = (meta > 64'hFFFF_FFFF) || (meta > 64'(total));
            data  = ovf ? 32'd0 : total - meta[31:0];
            clus  = data / 32'(spc);
            if (clus < fvg_pkg::LIMIT_FAT12)      r.volume_type = fvg_pkg::TYPE_FAT12;
            else if (clus < fvg_pkg::LIMIT_FAT16) r.volume_type = fvg_pkg::TYPE_FAT16;
            else if (clus < fvg_pkg::LIMIT_FAT32) r.volume_type = fvg_pkg::TYPE_FAT32;
            else                                  r.volume_type = fvg_pkg::TYPE_ERROR;
            r.root_start = (r.volume_type == fvg_pkg::TYPE_FAT12 ||
                            r.volume_type == fvg_pkg::TYPE_FAT16)
                           ? 32'(meta - rds) : rclus;
            r.total_sectors    = total;
            r.fat_sectors      = fat;
            r.root_dir_sectors = rds[12:0];
            r.data_start       = meta[31:0];
            r.fat_start        = rsv;
            r.data_sectors     = data;
            r.cluster_count    = clus;
            r.ovf              = ovf;
        end
        pending_layouts.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compare one output transfer with the oldest pending layout.
    function void check_layout(logic [231:0] d);
        fvg_pkg::t_res e;
        if (pending_layouts.size() == 0) begin
            $error("unexpected output transfer 0x%0h", d);
            errors++;
            return;
        end
        e = pending_layouts.pop_front();
        cmp("total_sectors",     e.total_sectors,          d[31:0]);
        cmp("fat_sectors",       e.fat_sectors,            d[63:32]);
        cmp("root_dir_sectors",  32'(e.root_dir_sectors),  32'(d[76:64]));
        cmp("data_start",        e.data_start,             d[108:77]);
        cmp("fat_start",         32'(e.fat_start),         32'(d[124:109]));
        cmp("data_sectors",      e.data_sectors,           d[156:125]);
        cmp("cluster_count",     e.cluster_count,          d[188:157]);
        cmp("volume_type",       32'(e.volume_type),       32'(d[190:189]));
        cmp("root_start",        e.root_start,             d[222:191]);
        cmp("bad_parameters",    32'(e.bad),               32'(d[223]));
        cmp("metadata_overflow", 32'(e.ovf),               32'(d[224]));
        cmp("pad",               32'd0,                    32'(d[231:225]));
    endfunction
endclass

module tb_fat_volume_geometry;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 49;
    localparam int N_RANDOM = 830;
    localparam int LIMIT    = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [191:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [231:0] o_m_axis_tdata;

    geometry_scoreboard sb = new();
    bit stim_done = 1'b0;
    int cycles = 0;

    always #5 i_clk = ~i_clk;

    fat_volume_geometry dut (.*);

    // Gap length: mostly zero or short, occasionally long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [191:0] pack_block(
        logic [15:0] bps, logic [7:0] spc, logic [15:0] rsv, logic [7:0] nfat,
        logic [15:0] nroot, logic [15:0] tss, logic [31:0] tsl,
        logic [15:0] fss, logic [31:0] fsl, logic [31:0] rclus);
        return {rclus, fsl, fss, tsl, tss, nroot, nfat, rsv, spc, bps};
    endfunction

    // Offer one block and hold it until the transfer happens.
    task automatic send_block(logic [191:0] blk, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= blk;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_block(blk);
    endtask

    // Mostly plausible volumes of each type, the rest raw noise.
    function automatic logic [191:0] random_block();
        logic [15:0] bps, rsv, tss, fss, nroot;
        logic [7:0]  spc, nfat;
        logic [31:0] tsl, fsl;
        int kind;
        kind = $urandom_range(9);
        if (kind < 2)
            return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        bps   = 16'd512 << $urandom_range(3);
        spc   = 8'd1 << $urandom_range(7);
        rsv   = 16'($urandom_range(1, 64));
        nfat  = 8'($urandom_range(1, 2));
        nroot = (kind == 9) ? 16'd0 : 16'($urandom_range(0, 1024));
        case ($urandom_range(3))
            0: begin tss = 16'($urandom_range(1, 65535)); tsl = $urandom(); end
            1: begin tss = 16'd0; tsl = $urandom_range(0, 200000); end
            2: begin tss = 16'd0; tsl = $urandom_range(65536, 32'h0FFF_FFFF); end
            default: begin tss = 16'd0; tsl = $urandom(); end
        endcase
        fss = ($urandom_range(1)) ? 16'($urandom_range(1, 300)) : 16'd0;
        fsl = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(1, 100000));
        if ($urandom_range(15) == 0) bps = 16'($urandom_range(0, 511));
        if ($urandom_range(15) == 0) spc = 8'd0;
        return pack_block(bps, spc, rsv, nfat, nroot, tss, tsl, fss, fsl, $urandom());
    endfunction

    // Source side: directed corners first, then random volumes.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // bad sector size, all-zero fields, and zero cluster size at the lowest legal sector size
        send_block(pack_block(16'd511, 8'd1, 1, 2, 512, 2880, 0, 9, 0, 2), 0);
        send_block(pack_block(16'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_block(pack_block(16'd512, 8'd0, 1, 2, 224, 2880, 0, 9, 0, 2), 0);
        // classic floppy, two FAT32 volumes and all-ones fields
        send_block(pack_block(16'd512, 8'd1, 1, 2, 224, 2880, 0, 9, 0, 2), 0);
        send_block(pack_block(16'd512, 8'd4, 4, 2, 512, 0, 1000000, 245, 0, 2), 1);
        send_block(pack_block(16'd512, 8'd8, 32, 2, 0, 0, 32'd20000000, 0, 32'd20000, 2), 1);
        send_block(pack_block(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                              32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
        send_block(pack_block(16'hFFFF, 8'hFF, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0,
                              32'hFFFF_FFFF), 0);
        // largest root directory with overflow past 32 bits, one spare sector, and an exact fit
        send_block(pack_block(16'd512, 8'd1, 16'hFFFF, 8'hFF, 16'hFFFF, 0,
                              32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 7), 0);
        send_block(pack_block(16'd512, 8'd1, 1, 2, 16, 21, 0, 9, 0, 5), 0);
        send_block(pack_block(16'd512, 8'd1, 1, 2, 16, 20, 0, 9, 0, 5), 0);
        // cluster count boundaries between the types
        send_block(pack_block(16'd512, 8'd1, 1, 1, 0, 0, 32'd4085, 0, 0, 9), 0);
        send_block(pack_block(16'd512, 8'd1, 1, 1, 0, 0, 32'd4086, 0, 0, 9), 0);
        send_block(pack_block(16'd512, 8'd1, 1, 1, 0, 0, 32'd65525, 0, 0, 9), 0);
        send_block(pack_block(16'd512, 8'd1, 1, 1, 0, 0, 32'd65526, 0, 0, 9), 0);
        send_block(pack_block(16'd512, 8'd1, 0, 0, 0, 0, 32'd268435444, 0, 0, 9), 0);
        send_block(pack_block(16'd512, 8'd1, 0, 0, 0, 0, 32'd268435445, 0, 0, 9), 0);
        send_block(pack_block(16'd513, 8'd3, 0, 0, 1, 0, 32'd268435445, 0, 0, 9), 0);
        for (int k = 0; k < N_RANDOM; k++)
            send_block(random_block(), ($urandom_range(3) == 0));
        i_s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Sink side: random stalls, one long hold-off early to back up the pipeline.
    initial begin
        int g;
        repeat (12) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        forever begin
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if ($urandom_range(3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_layout(o_m_axis_tdata);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("fat_volume_geometry regression: fail");
            $finish;
        end
    end

    // Drain, then let the latency pass before the verdict.
    initial begin
        wait (stim_done);
        while (sb.pending_layouts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("fat_volume_geometry regression: pass");
        else
            $display("fat_volume_geometry regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
